// File: rtl/core/fmsp_pkg.sv
// Shared types, character codes and mask functions for the file-mode string parser.
`default_nettype none
package fmsp_pkg;

	localparam int unsigned MODE_W = 12;
	localparam int unsigned UMASK_W = 9;
	localparam int unsigned CHAR_W = 8;

	localparam logic [UMASK_W-1:0] UMASK_RST = 9'd18;
	localparam logic [MODE_W-1:0] START_MODE_RST = 12'd420;

	// configuration register indexes
	localparam logic CFG_UMASK = 1'b0;
	localparam logic CFG_START_MODE = 1'b1;

	// operator codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_SET = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3d;
	localparam logic [CHAR_W-1:0] CH_U = 8'h75;
	localparam logic [CHAR_W-1:0] CH_G = 8'h67;
	localparam logic [CHAR_W-1:0] CH_O = 8'h6f;
	localparam logic [CHAR_W-1:0] CH_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_R = 8'h72;
	localparam logic [CHAR_W-1:0] CH_W = 8'h77;
	localparam logic [CHAR_W-1:0] CH_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_BIG_X = 8'h58;
	localparam logic [CHAR_W-1:0] CH_S = 8'h73;
	localparam logic [CHAR_W-1:0] CH_T = 8'h74;

	typedef struct packed {
		logic valid;
		logic [MODE_W-1:0] final_mode;
		logic parse_error;
		logic [CHAR_W-1:0] stop_character;
		logic octal_overflow;
	} fmsp_result_t;

	function automatic logic is_octal(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_copy(input logic [CHAR_W-1:0] c);
		return (c == CH_U) || (c == CH_G) || (c == CH_O);
	endfunction

	function automatic logic is_who(input logic [CHAR_W-1:0] c);
		return is_copy(c) || (c == CH_A);
	endfunction

	function automatic logic is_perm(input logic [CHAR_W-1:0] c);
		return (c == CH_R) || (c == CH_W) || (c == CH_X) || (c == CH_BIG_X) ||
			(c == CH_S) || (c == CH_T);
	endfunction

	function automatic logic is_op(input logic [CHAR_W-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQUAL);
	endfunction

	function automatic logic [1:0] op_code(input logic [CHAR_W-1:0] c);
		logic [1:0] r;
		r = OP_SET;
		if (c == CH_PLUS) r = OP_ADD;
		else if (c == CH_MINUS) r = OP_SUB;
		return r;
	endfunction

	function automatic logic [MODE_W-1:0] who_bits(input logic [CHAR_W-1:0] c);
		logic [MODE_W-1:0] r;
		r = 12'o6777;
		if (c == CH_U) r = 12'o4700;
		else if (c == CH_G) r = 12'o2070;
		else if (c == CH_O) r = 12'o0007;
		return r;
	endfunction

	// X counts only if some execute bit was set when the pass began
	function automatic logic [MODE_W-1:0] perm_bits(input logic [CHAR_W-1:0] c,
			input logic [MODE_W-1:0] pass_mode);
		logic [MODE_W-1:0] r;
		r = 12'o1000;
		if (c == CH_R) r = 12'o0444;
		else if (c == CH_W) r = 12'o0222;
		else if (c == CH_X) r = 12'o0111;
		else if (c == CH_BIG_X)
			r = (pass_mode[6] | pass_mode[3] | pass_mode[0]) ? 12'o0111 : 12'o0000;
		else if (c == CH_S) r = 12'o6000;
		return r;
	endfunction

	// replicate one rwx triple of the mode into all three triples
	function automatic logic [MODE_W-1:0] copy_bits(input logic [CHAR_W-1:0] c,
			input logic [MODE_W-1:0] mode);
		logic [2:0] t;
		t = mode[2:0];
		if (c == CH_U) t = mode[8:6];
		else if (c == CH_G) t = mode[5:3];
		return {3'b000, t, t, t};
	endfunction

	function automatic logic [MODE_W-1:0] apply_op(input logic [MODE_W-1:0] mode,
			input logic [MODE_W-1:0] who, input logic [UMASK_W-1:0] umask,
			input logic [1:0] op, input logic [MODE_W-1:0] perm);
		logic [MODE_W-1:0] w;
		logic [MODE_W-1:0] m;
		logic [MODE_W-1:0] r;
		w = (who != '0) ? who : {3'b111, ~umask};
		m = w & perm;
		case (op)
			OP_ADD: r = mode | m;
			OP_SUB: r = mode & ~m;
			default: r = (mode & ~(w & 12'o0777)) | m;
		endcase
		if (perm == '0) r = mode;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/fmsp_core.sv
// Parser state and per-byte update of the file-mode string parser.
`default_nettype none
module fmsp_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic [fmsp_pkg::CHAR_W-1:0] char_in,
	input  wire logic [fmsp_pkg::UMASK_W-1:0] umask_bits,
	input  wire logic [fmsp_pkg::MODE_W-1:0] start_mode,
	output fmsp_pkg::fmsp_result_t result
);
	import fmsp_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_OCTAL,
		PH_WHO,
		PH_OPCHAR,
		PH_PERMS,
		PH_COPY,
		PH_STOPPED
	} phase_t;

	phase_t phase_q, phase_d;
	logic [MODE_W-1:0] cur_q, cur_d, pass_q, pass_d, who_q, who_d, perm_q, perm_d;
	logic [1:0] op_q, op_d;
	logic [CHAR_W-1:0] stop_q, stop_d;
	logic ovf_q, ovf_d;

	logic [MODE_W-1:0] cur_b, pass_b, who_b, perm_b;
	logic ovf_b;
	phase_t phase_b;

	always_comb begin
		// a new string reloads the mode from the start register
		cur_b = cur_q;
		pass_b = pass_q;
		who_b = who_q;
		perm_b = perm_q;
		ovf_b = ovf_q;
		phase_b = phase_q;
		if (phase_q == PH_START) begin
			cur_b = start_mode;
			pass_b = start_mode;
			who_b = '0;
			perm_b = '0;
			ovf_b = 1'b0;
			if (char_in != CH_NUL && !is_octal(char_in)) phase_b = PH_WHO;
		end

		cur_d = cur_b;
		pass_d = pass_b;
		who_d = who_b;
		perm_d = perm_b;
		ovf_d = ovf_b;
		op_d = op_q;
		stop_d = stop_q;
		phase_d = phase_b;
		result = '0;

		if (step) begin
			if (char_in == CH_NUL) begin
				if (phase_q == PH_PERMS)
					cur_d = apply_op(cur_b, who_b, umask_bits, op_q, perm_b);
				result.valid = 1'b1;
				result.final_mode = cur_d;
				result.parse_error = (phase_q == PH_STOPPED);
				result.stop_character = (phase_q == PH_STOPPED) ? stop_q : CH_NUL;
				result.octal_overflow = ovf_b;
				phase_d = PH_START;
				who_d = '0;
				op_d = OP_ADD;
				perm_d = '0;
				stop_d = CH_NUL;
				ovf_d = 1'b0;
			end else begin
				case (phase_b)
					PH_START: begin
						// leading octal digit
						cur_d = {9'd0, char_in[2:0]};
						phase_d = PH_OCTAL;
					end
					PH_OCTAL: begin
						if (is_octal(char_in)) begin
							if (cur_b[11:9] != 3'd0) ovf_d = 1'b1;
							cur_d = {cur_b[8:0], char_in[2:0]};
						end else begin
							stop_d = char_in;
							phase_d = PH_STOPPED;
						end
					end
					PH_WHO: begin
						if (is_who(char_in)) begin
							who_d = who_b | who_bits(char_in);
						end else if (is_op(char_in)) begin
							op_d = op_code(char_in);
							perm_d = '0;
							phase_d = PH_OPCHAR;
						end else if (char_in == CH_COMMA) begin
							// comma where an operator is expected opens a new pass
							pass_d = cur_b;
							who_d = '0;
						end else begin
							stop_d = char_in;
							phase_d = PH_STOPPED;
						end
					end
					PH_OPCHAR: begin
						if (is_copy(char_in)) begin
							perm_d = copy_bits(char_in, cur_b);
							cur_d = apply_op(cur_b, who_b, umask_bits, op_q, perm_d);
							phase_d = PH_COPY;
						end else if (is_perm(char_in)) begin
							perm_d = perm_bits(char_in, pass_b);
							phase_d = PH_PERMS;
						end else if (char_in == CH_COMMA) begin
							who_d = '0;
							phase_d = PH_WHO;
						end else begin
							stop_d = char_in;
							phase_d = PH_STOPPED;
						end
					end
					PH_PERMS, PH_COPY: begin
						if (phase_b == PH_PERMS && is_perm(char_in)) begin
							perm_d = perm_b | perm_bits(char_in, pass_b);
						end else begin
							if (phase_b == PH_PERMS)
								cur_d = apply_op(cur_b, who_b, umask_bits, op_q, perm_b);
							if (is_op(char_in)) begin
								op_d = op_code(char_in);
								perm_d = '0;
								phase_d = PH_OPCHAR;
							end else if (char_in == CH_COMMA) begin
								who_d = '0;
								phase_d = PH_WHO;
							end else begin
								stop_d = char_in;
								phase_d = PH_STOPPED;
							end
						end
					end
					default: begin
						// stopped: drop bytes until the terminator
					end
				endcase
			end
		end else begin
			cur_d = cur_q;
			pass_d = pass_q;
			who_d = who_q;
			perm_d = perm_q;
			ovf_d = ovf_q;
			phase_d = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cur_q <= START_MODE_RST;
			pass_q <= START_MODE_RST;
			who_q <= '0;
			perm_q <= '0;
			op_q <= OP_ADD;
			stop_q <= CH_NUL;
			ovf_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cur_q <= cur_d;
			pass_q <= pass_d;
			who_q <= who_d;
			perm_q <= perm_d;
			op_q <= op_d;
			stop_q <= stop_d;
			ovf_q <= ovf_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/file_mode_string_parser_unit.sv
// Top level of the file-mode string parser: input stage, configuration and result register.
// The result register loads when a terminator steps out of the input stage.
// Throughput: one word per cycle unless stalled; the core updates all state on each step.
// The input stalls only when a terminator sits in the input stage while a result is held.
// Reset (arst_n low, asynchronous): pipeline empty, parser at string start,
// umask_bits = 18 and start_mode = 420; no clearing pass is needed.
`default_nettype none
module file_mode_string_parser_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [fmsp_pkg::CHAR_W-1:0] character,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [fmsp_pkg::MODE_W-1:0] final_mode,
	output logic parse_error,
	output logic [fmsp_pkg::CHAR_W-1:0] stop_character,
	output logic octal_overflow,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [fmsp_pkg::MODE_W-1:0] cfg_data
);
	import fmsp_pkg::*;

	logic [UMASK_W-1:0] umask_q;
	logic [MODE_W-1:0] start_mode_q;

	logic valid_s1;
	logic [CHAR_W-1:0] char_s1;

	logic out_valid_q;
	logic [MODE_W-1:0] mode_q;
	logic err_q, ovf_q;
	logic [CHAR_W-1:0] stop_q;

	logic in_take, out_take, can_step;
	fmsp_result_t res;

	// configuration registers; umask acts at once, start_mode at the next string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			umask_q <= UMASK_RST;
			start_mode_q <= START_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UMASK: umask_q <= cfg_data[UMASK_W-1:0];
				CFG_START_MODE: start_mode_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// the stage word may advance unless it is a terminator and the result slot stays full
	assign out_take = out_valid_q && !out_stall;
	assign can_step = valid_s1 && !(char_s1 == CH_NUL && out_valid_q && !out_take);
	assign in_stall = valid_s1 && !can_step;
	assign in_take = in_valid && !in_stall;

	// input stage: hold the word while stalled, load a fresh one on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (can_step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) char_s1 <= character;
	end

	fmsp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (can_step),
		.char_in    (char_s1),
		.umask_bits (umask_q),
		.start_mode (start_mode_q),
		.result     (res)
	);

	// result register: load on a terminator, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mode_q <= res.final_mode;
			err_q <= res.parse_error;
			stop_q <= res.stop_character;
			ovf_q <= res.octal_overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign final_mode = mode_q;
	assign parse_error = err_q;
	assign stop_character = stop_q;
	assign octal_overflow = ovf_q;

endmodule
`default_nettype wire

// File: rtl/core/fmsp_checker.sv
// Port-level checks of the file-mode string parser and their binding to the top level.
`default_nettype none
module fmsp_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_stall,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [11:0] final_mode,
	input  wire logic parse_error,
	input  wire logic [7:0] stop_character,
	input  wire logic octal_overflow
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(final_mode) &&
			$stable(parse_error) && $stable(stop_character) && $stable(octal_overflow))
		else $error("stalled result word changed");

	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_clean_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_error |-> stop_character == 8'd0)
		else $error("stop byte reported on a clean parse");

	a_error_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> stop_character != 8'd0)
		else $error("error reported with a terminator stop byte");

endmodule

bind file_mode_string_parser_unit fmsp_checker u_fmsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.final_mode     (final_mode),
	.parse_error    (parse_error),
	.stop_character (stop_character),
	.octal_overflow (octal_overflow)
);
`default_nettype wire
